FILE: rtl/core/ycbsv_pkg.sv
package ycbsv_pkg;

  localparam int ImgW = 256;
  localparam int ImgH = 256;
  localparam int MaxBlk = 32;
  localparam int AddrW = 16;

  localparam logic [1:0] CfgMode = 2'd0;
  localparam logic [1:0] CfgBlk = 2'd1;
  localparam logic [1:0] CfgWid = 2'd2;
  localparam logic [1:0] CfgHgt = 2'd3;

  localparam logic [2:0] ModeRt = 3'd0;
  localparam logic [2:0] ModeY = 3'd1;
  localparam logic [2:0] ModeCb = 3'd2;
  localparam logic [2:0] ModeCr = 3'd3;
  localparam logic [2:0] ModeCblk = 3'd4;
  localparam logic [2:0] ModeYblk = 3'd5;

  localparam logic CmdStore = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       bad_coordinate;
  } out_item_t;

endpackage

FILE: rtl/core/ycbcr_block_subsample_view_unit.sv
// YCbCr block subsample view unit.
// Input: in_start/in_busy command port, payload in_item (cmd, column, row, RGB).
//   A beat is taken when in_start is high and in_busy is low.
// Store (cmd 0): converts RGB to 8.4 Y/Cb/Cr and writes the three pixel
//   memories and gives no result; the write lands in the cycle after busy
//   drops. A store outside the image is dropped, busy stays low.
// Query (cmd 1): reads the pixel and gives one result beat on out_item,
//   marked by out_valid for one cycle after the last busy cycle. The
//   receiver cannot stall. Outside the image: flagged result next cycle, no
//   busy. Gray views: read, then output. Round trip: read, the multiply
//   steps that share one 17x17 multiplier (four of them here), output.
// Block views: compare and subtract find the block origin, then the
//   clipped block is walked entry by entry through the single memory read
//   port (up to 1024 entries), a 22-bit restoring divider runs once per
//   averaged channel, then the inverse steps.
// Configuration: cfg_valid/cfg_ready write port, cfg_index selects
//   view_mode, block_size, image_width, image_height. cfg_ready is always high.
// Reset (rst_n low, synchronous) restores the register defaults and idles
//   the sequencer. Pixel memories are not cleared; unwritten pixels read as
//   don't care.
module ycbcr_block_subsample_view_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_start,
  output logic                  in_busy,
  input  ycbsv_pkg::in_item_t   in_item,
  output logic                  out_valid,
  output ycbsv_pkg::out_item_t  out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [8:0]            cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_FWD, S_WR, S_RD, S_RDW, S_ALN, S_SCAN, S_SCANW, S_DIV, S_INV, S_OUT
  } state_t;

  state_t state_r;

  logic [2:0] mode_r;
  logic [5:0] blk_r;
  logic [8:0] wid_r, hgt_r;

  // pixel memories
  localparam int ImgMem = ycbsv_pkg::ImgW * ycbsv_pkg::ImgH;
  logic [11:0] ymem [ImgMem];
  logic [11:0] bmem [ImgMem];
  logic [11:0] rmem [ImgMem];

  ycbsv_pkg::in_item_t itm_r;
  logic        we_r;
  logic [ycbsv_pkg::AddrW-1:0] addr_r;
  logic [11:0] yd_r, bd_r, rd_r;     // read data
  logic [11:0] yv_r, bv_r, rv_r;     // working channel values
  logic [11:0] wy_r, wb_r, wr_r;     // write data

  // shared multiplier
  logic signed [16:0] ma, mb;
  logic signed [33:0] mp;
  assign mp = ma * mb;

  logic [2:0]  step_r;
  logic signed [35:0] acc_r [3];

  // block scan
  logic [5:0]  bs;
  logic [8:0]  weff, heff;         // active size, capped at the memory size
  logic [7:0]  xr_r, yr_r;         // column / row remainder by block edge
  logic [12:0] d_r;                // shifted block edge
  logic [7:0]  x0_r, y0_r, xx_r, yy_r, xe_r, ye_r;
  logic [21:0] sb_r, sy_r, sr_r;   // block sums
  logic [10:0] cnt_r;
  logic        sel_r;              // divider pass: 0 first, 1 second
  logic [4:0]  dstep_r;
  logic [21:0] rem_r, quo_r;

  assign cfg_ready = 1'b1;
  assign in_busy   = (state_r != S_IDLE);

  always_comb begin
    bs = blk_r;
    if (blk_r < 6'd2) bs = 6'd2;
    if (blk_r > 6'(ycbsv_pkg::MaxBlk)) bs = 6'(ycbsv_pkg::MaxBlk);
  end

  assign weff = (wid_r > 9'(ycbsv_pkg::ImgW)) ? 9'(ycbsv_pkg::ImgW) : wid_r;
  assign heff = (hgt_r > 9'(ycbsv_pkg::ImgH)) ? 9'(ycbsv_pkg::ImgH) : hgt_r;

  logic in_img;
  assign in_img = ({1'b0, in_item.column} < wid_r) && ({1'b0, in_item.row} < hgt_r);

  always_comb begin
    ma = '0;
    mb = '0;
    case (step_r)
      3'd0: begin ma = 17'(itm_r.red_in); mb = 17'sd4899; end
      3'd1: begin ma = 17'(itm_r.green_in); mb = 17'sd9617; end
      3'd2: begin ma = 17'(itm_r.blue_in); mb = 17'sd1868; end
      3'd3: begin ma = 17'(rv_r) - 17'sd2048; mb = 17'sd22970; end
      3'd4: begin ma = 17'(bv_r) - 17'sd2048; mb = -17'sd5638; end
      3'd5: begin ma = 17'(rv_r) - 17'sd2048; mb = -17'sd11700; end
      3'd6: begin ma = 17'(bv_r) - 17'sd2048; mb = 17'sd29032; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // forward chroma terms are small; done with shifts and adds of constants
  logic [31:0] cbf, crf;
  always_comb begin
    cbf = 32'd2097152 + 32'd8192 * itm_r.blue_in - 32'd2765 * itm_r.red_in
        - 32'd5427 * itm_r.green_in + 32'd512;
    crf = 32'd2097152 + 32'd8192 * itm_r.red_in - 32'd6860 * itm_r.green_in
        - 32'd1332 * itm_r.blue_in + 32'd512;
  end

  function automatic logic [7:0] to8(input logic signed [35:0] a);
    logic [17:0] q;
    begin
      q = a[35:18];
      if (a < 0) to8 = 8'd0;
      else if (q > 18'd255) to8 = 8'd255;
      else to8 = q[7:0];
    end
  endfunction

  // memories
  always_ff @(posedge clk) begin
    if (we_r) begin
      ymem[addr_r] <= wy_r;
      bmem[addr_r] <= wb_r;
      rmem[addr_r] <= wr_r;
    end
    yd_r <= ymem[addr_r];
    bd_r <= bmem[addr_r];
    rd_r <= rmem[addr_r];
  end

  logic [21:0] trial;
  logic [21:0] divsrc;
  assign divsrc = (mode_r == ycbsv_pkg::ModeYblk) ? sy_r : (sel_r ? sr_r : sb_r);
  assign trial = {rem_r[20:0], divsrc[5'd21 - dstep_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mode_r    <= ycbsv_pkg::ModeRt;
      blk_r     <= 6'd2;
      wid_r     <= 9'd256;
      hgt_r     <= 9'd256;
      out_valid <= 1'b0;
      we_r      <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      we_r      <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          ycbsv_pkg::CfgMode: mode_r <= cfg_data[2:0];
          ycbsv_pkg::CfgBlk:  blk_r  <= cfg_data[5:0];
          ycbsv_pkg::CfgWid:  wid_r  <= cfg_data;
          ycbsv_pkg::CfgHgt:  hgt_r  <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_start) begin
            itm_r  <= in_item;
            addr_r <= {in_item.row, in_item.column};
            step_r <= 3'd0;
            acc_r[0] <= '0;
            if (in_item.cmd == ycbsv_pkg::CmdStore) begin
              if (in_img) state_r <= S_FWD;
            end else if (!in_img) begin
              out_item  <= '{8'd0, 8'd0, 8'd0, 1'b1};
              out_valid <= 1'b1;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_FWD: begin
          acc_r[0] <= acc_r[0] + 36'(mp);
          step_r   <= step_r + 3'd1;
          if (step_r == 3'd2) state_r <= S_WR;
        end
        S_WR: begin
          wy_r    <= 12'((acc_r[0] + 36'sd512) >>> 10);
          wb_r    <= cbf[21:10];
          wr_r    <= crf[21:10];
          we_r    <= 1'b1;
          state_r <= S_IDLE;
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          yv_r <= yd_r;
          bv_r <= bd_r;
          rv_r <= rd_r;
          case (mode_r)
            ycbsv_pkg::ModeY: begin
              out_item <= '{yd_r[11:4], yd_r[11:4], yd_r[11:4], 1'b0};
              out_valid <= 1'b1;
              state_r <= S_IDLE;
            end
            ycbsv_pkg::ModeCb: begin
              out_item <= '{bd_r[11:4], bd_r[11:4], bd_r[11:4], 1'b0};
              out_valid <= 1'b1;
              state_r <= S_IDLE;
            end
            ycbsv_pkg::ModeCr: begin
              out_item <= '{rd_r[11:4], rd_r[11:4], rd_r[11:4], 1'b0};
              out_valid <= 1'b1;
              state_r <= S_IDLE;
            end
            ycbsv_pkg::ModeCblk, ycbsv_pkg::ModeYblk: begin
              xr_r    <= itm_r.column;
              yr_r    <= itm_r.row;
              d_r     <= {bs, 7'd0};
              dstep_r <= '0;
              state_r <= S_ALN;
              step_r  <= 3'd7;
            end
            default: begin
              step_r  <= 3'd3;
              state_r <= S_INV;
            end
          endcase
        end
        S_ALN: begin
          // remainder by the block edge, one shifted edge per cycle;
          // block origin is the coordinate minus its remainder
          if (dstep_r == 5'd8) begin
            x0_r    <= itm_r.column - xr_r;
            y0_r    <= itm_r.row - yr_r;
            state_r <= S_SCAN;
          end else begin
            if (13'(xr_r) >= d_r) xr_r <= xr_r - d_r[7:0];
            if (13'(yr_r) >= d_r) yr_r <= yr_r - d_r[7:0];
            d_r     <= {1'b0, d_r[12:1]};
            dstep_r <= dstep_r + 5'd1;
          end
        end
        S_SCAN: begin
          // step 7 marks scan setup
          xx_r  <= x0_r;
          yy_r  <= y0_r;
          xe_r  <= 8'(((9'(x0_r) + 9'(bs)) < weff ? 9'(x0_r) + 9'(bs) : weff) - 9'd1);
          ye_r  <= 8'(((9'(y0_r) + 9'(bs)) < heff ? 9'(y0_r) + 9'(bs) : heff) - 9'd1);
          addr_r <= {y0_r, x0_r};
          sb_r <= '0; sy_r <= '0; sr_r <= '0;
          cnt_r <= '0;
          state_r <= S_SCANW;
          step_r <= 3'd0;
        end
        S_SCANW: begin
          // step 0: address issued; step 1: data valid; step 2: accumulate
          if (step_r == 3'd0) begin
            step_r <= 3'd1;
          end else if (step_r == 3'd1) begin
            step_r <= 3'd2;
          end else begin
            sb_r  <= sb_r + 22'(bd_r);
            sy_r  <= sy_r + 22'(yd_r);
            sr_r  <= sr_r + 22'(rd_r);
            cnt_r <= cnt_r + 11'd1;
            step_r <= 3'd0;
            if (xx_r == xe_r) begin
              if (yy_r == ye_r) begin
                state_r <= S_DIV;
                sel_r   <= 1'b0;
                dstep_r <= '0;
                rem_r   <= '0;
                quo_r   <= '0;
              end else begin
                yy_r   <= yy_r + 8'd1;
                xx_r   <= x0_r;
                addr_r <= {yy_r + 8'd1, x0_r};
              end
            end else begin
              xx_r   <= xx_r + 8'd1;
              addr_r <= {yy_r, xx_r + 8'd1};
            end
          end
        end
        S_DIV: begin
          if (trial >= 22'(cnt_r)) begin
            rem_r <= trial - 22'(cnt_r);
            quo_r <= {quo_r[20:0], 1'b1};
          end else begin
            rem_r <= trial;
            quo_r <= {quo_r[20:0], 1'b0};
          end
          dstep_r <= dstep_r + 5'd1;
          if (dstep_r == 5'd21) begin
            if (mode_r == ycbsv_pkg::ModeYblk) begin
              yv_r    <= 12'(trial >= 22'(cnt_r) ? {quo_r[20:0], 1'b1} : {quo_r[20:0], 1'b0});
              step_r  <= 3'd3;
              state_r <= S_INV;
            end else if (!sel_r) begin
              bv_r    <= 12'(trial >= 22'(cnt_r) ? {quo_r[20:0], 1'b1} : {quo_r[20:0], 1'b0});
              sel_r   <= 1'b1;
              dstep_r <= '0;
              rem_r   <= '0;
              quo_r   <= '0;
            end else begin
              rv_r    <= 12'(trial >= 22'(cnt_r) ? {quo_r[20:0], 1'b1} : {quo_r[20:0], 1'b0});
              step_r  <= 3'd3;
              state_r <= S_INV;
            end
          end
        end
        S_INV: begin
          // accumulators: 0 red, 1 green, 2 blue; Y term seeded at step 3
          case (step_r)
            3'd3: begin
              acc_r[0] <= {10'd0, yv_r, 14'd0} + 36'(mp);
              acc_r[1] <= {10'd0, yv_r, 14'd0};
              acc_r[2] <= {10'd0, yv_r, 14'd0};
            end
            3'd4, 3'd5: acc_r[1] <= acc_r[1] + 36'(mp);
            default: acc_r[2] <= acc_r[2] + 36'(mp);
          endcase
          step_r <= step_r + 3'd1;
          if (step_r == 3'd6) state_r <= S_OUT;
        end
        S_OUT: begin
          out_item  <= '{to8(acc_r[0]), to8(acc_r[1]), to8(acc_r[2]), 1'b0};
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
